>>> rtl/png_scanline_unfilter_assert.svh
// assertion macros for the png scanline unfilter
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is held
`define PNGUF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, active during reset too
`define PNGUF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNGUF_ASSERT(lbl, clk, rst_n, prop, msg)
`define PNGUF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/pnguf_pkg.sv
package pnguf_pkg;

  // filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // per-item control carried through the reconstruction stage
  typedef struct packed {
    logic [2:0] filter;
    logic       has_left;
    logic       has_above;
    logic       compute;
    logic       emit;
    logic       bad;
    logic       eor;
    logic       eoi;
  } pnguf_ctl_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] sab;
    logic [9:0] cc;
    logic [7:0] pick;
    pa  = (b > c) ? 10'(b - c) : 10'(c - b);
    pb  = (a > c) ? 10'(a - c) : 10'(c - a);
    sab = 10'(a) + 10'(b);
    cc  = {1'b0, c, 1'b0};
    pc  = (sab > cc) ? (sab - cc) : (cc - sab);
    if (pa <= pb && pa <= pc) begin
      pick = a;
    end else if (pb <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

>>> rtl/pnguf_line_ram.sv
module pnguf_line_ram
  import pnguf_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] line_mem_r [0:DEPTH-1];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, output holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/pnguf_recon.sv
module pnguf_recon
  import pnguf_pkg::*;
#(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned SW    = 3
) (
  input  logic          clk,
  input  pnguf_ctl_t    ctl,
  input  logic [7:0]    x,
  input  logic [SW-1:0] slot,
  input  logic [7:0]    above_byte,
  input  logic          upd_en,
  output logic [7:0]    recon
);

  logic [7:0] left_hist_r [0:SLOTS-1];
  logic [7:0] ul_hist_r   [0:SLOTS-1];
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] ab_sum;
  logic [7:0] pred;

  // neighbors count as zero before the first full pixel and on the first row
  assign a      = ctl.has_left  ? left_hist_r[slot] : 8'd0;
  assign c      = ctl.has_left  ? ul_hist_r[slot]   : 8'd0;
  assign b      = ctl.has_above ? above_byte        : 8'd0;
  assign ab_sum = 9'(a) + 9'(b);

  always_comb begin
    case (ctl.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign recon = x + pred;

  always_ff @(posedge clk) begin
    if (upd_en) begin
      left_hist_r[slot] <= recon;
      ul_hist_r[slot]   <= b;
    end
  end

endmodule

>>> rtl/png_scanline_unfilter.sv
// png scanline unfilter: none, sub, up, average and paeth reconstruction
// data path: input transfer, reconstruction stage register, output register
// throughput: one byte per cycle unless the output stalls, set by the line
// ram's single read port (read on transfer, data back next cycle in the stage)
// reset: control state and configuration return to defaults, next byte is a
// filter type; the line ram is not cleared, the first row of an image ignores it
`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter
  import pnguf_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = 4096,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // filtered byte stream in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_stream_byte,
  // reconstructed bytes out
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_byte,
  output logic                  out_bad_filter,
  output logic                  out_end_of_row,
  output logic                  out_end_of_image
);

  // column counter width holds the row length itself
  localparam int unsigned CW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned CMPW = (CW > 13) ? CW : 13;
  localparam int unsigned AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned SW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0]  bpp_r;
  logic [12:0] row_bytes_r;
  logic [15:0] row_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= 4'd4;
      row_bytes_r <= 13'd1024;
      row_count_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BYTES_PER_PIXEL: bpp_r       <= cfg_data[3:0];
        CFG_ROW_BYTES:       row_bytes_r <= cfg_data[12:0];
        CFG_ROW_COUNT:       row_count_r <= cfg_data[15:0];
        default:             ;  // unmapped index, write is dropped
      endcase
    end
  end

  // out-of-range settings are clamped to the legal range
  logic [3:0]      bpp_eff;
  logic [CMPW-1:0] rb_eff;
  logic [15:0]     rc_eff;

  always_comb begin
    bpp_eff = bpp_r;
    if (bpp_r == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp_r > 4'(MAX_PIXEL_BYTES)) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end
    rb_eff = CMPW'(row_bytes_r);
    if (row_bytes_r == 13'd0) begin
      rb_eff = CMPW'(1);
    end else if (CMPW'(row_bytes_r) > CMPW'(MAX_ROW_BYTES)) begin
      rb_eff = CMPW'(MAX_ROW_BYTES);
    end
    rc_eff = (row_count_r == 16'd0) ? 16'd1 : row_count_r;
  end

  // ---------------------------------------------------------------------------
  // stream position tracking, updated on each input transfer
  // ---------------------------------------------------------------------------
  logic          expect_type_r, expect_type_nxt;
  logic          drop_r, drop_nxt;
  logic [2:0]    filt_r, filt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          has_left_r, has_left_nxt;

  logic            in_xfer;
  logic [CMPW-1:0] col_inc;
  logic [16:0]     row_inc;
  logic            slot_wrap;
  pnguf_ctl_t      ctl_nxt;

  assign in_xfer   = in_valid && in_ready;
  assign col_inc   = CMPW'(col_r) + CMPW'(1);
  assign row_inc   = {1'b0, row_r} + 17'd1;
  assign slot_wrap = (4'(slot_r) == (bpp_eff - 4'd1));

  always_comb begin
    expect_type_nxt = expect_type_r;
    drop_nxt        = drop_r;
    filt_nxt        = filt_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    slot_nxt        = slot_r;
    has_left_nxt    = has_left_r;
    ctl_nxt         = '0;
    ctl_nxt.filter    = filt_r;
    ctl_nxt.has_left  = has_left_r;
    ctl_nxt.has_above = (row_r != 16'd0);
    if (expect_type_r) begin
      // filter type byte starts a row
      expect_type_nxt = 1'b0;
      col_nxt         = '0;
      slot_nxt        = '0;
      has_left_nxt    = 1'b0;
      if (!drop_r) begin
        if (in_stream_byte > {5'd0, FILT_PAETH}) begin
          drop_nxt    = 1'b1;
          ctl_nxt.emit = 1'b1;
          ctl_nxt.bad  = 1'b1;
        end else begin
          filt_nxt = in_stream_byte[2:0];
        end
      end
    end else begin
      ctl_nxt.compute = !drop_r;
      ctl_nxt.emit    = !drop_r;
      slot_nxt        = slot_wrap ? '0 : slot_r + SW'(1);
      has_left_nxt    = has_left_r || slot_wrap;
      col_nxt         = CW'(col_inc);
      if (col_inc >= rb_eff) begin
        col_nxt         = '0;
        expect_type_nxt = 1'b1;
        ctl_nxt.eor     = 1'b1;
        row_nxt         = row_inc[15:0];
        if (row_inc >= {1'b0, rc_eff}) begin
          row_nxt     = '0;
          ctl_nxt.eoi = 1'b1;
          drop_nxt    = 1'b0;  // a dropped image ends here
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_type_r <= 1'b1;
      drop_r        <= 1'b0;
      filt_r        <= FILT_NONE;
      col_r         <= '0;
      row_r         <= '0;
      slot_r        <= '0;
      has_left_r    <= 1'b0;
    end else if (in_xfer) begin
      expect_type_r <= expect_type_nxt;
      drop_r        <= drop_nxt;
      filt_r        <= filt_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      slot_r        <= slot_nxt;
      has_left_r    <= has_left_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // reconstruction stage: line ram data arrives here in the cycle after transfer
  // ---------------------------------------------------------------------------
  logic          b_valid_r;
  pnguf_ctl_t    b_ctl_r;
  logic [7:0]    b_x_r;
  logic [SW-1:0] b_slot_r;
  logic [AW-1:0] b_addr_r;

  logic       out_free;
  logic       b_advance;
  logic       ram_rd_en;
  logic       ram_wr_en;
  logic [7:0] above_byte;
  logic [7:0] recon;

  assign out_free  = !out_valid || out_ready;
  assign b_advance = b_valid_r && (!b_ctl_r.emit || out_free);
  assign in_ready  = !b_valid_r || b_advance;

  // only data bytes read the row above
  assign ram_rd_en = in_xfer && !expect_type_r;
  assign ram_wr_en = b_advance && b_ctl_r.compute;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_ready) begin
      b_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_ctl_r  <= ctl_nxt;
      b_x_r    <= in_stream_byte;
      b_slot_r <= slot_r;
      b_addr_r <= col_r[AW-1:0];
    end
  end

  pnguf_line_ram #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (b_addr_r),
    .wr_data (recon),
    .rd_en   (ram_rd_en),
    .rd_addr (col_r[AW-1:0]),
    .rd_data (above_byte)
  );

  pnguf_recon #(
    .SLOTS (MAX_PIXEL_BYTES),
    .SW    (SW)
  ) u_recon (
    .clk        (clk),
    .ctl        (b_ctl_r),
    .x          (b_x_r),
    .slot       (b_slot_r),
    .above_byte (above_byte),
    .upd_en     (ram_wr_en),
    .recon      (recon)
  );

  // ---------------------------------------------------------------------------
  // output register, parts the stage from a stalled consumer
  // ---------------------------------------------------------------------------
  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_bad_r;
  logic       out_eor_r;
  logic       out_eoi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_advance && b_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance && b_ctl_r.emit) begin
      out_pixel_r <= b_ctl_r.bad ? 8'd0 : recon;
      out_bad_r   <= b_ctl_r.bad;
      out_eor_r   <= b_ctl_r.eor;
      out_eoi_r   <= b_ctl_r.eoi;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_byte   = out_pixel_r;
  assign out_bad_filter   = out_bad_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_image = out_eoi_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `PNGUF_ASSERT(a_ram_no_collide, clk, rst_n,
                (ram_wr_en && ram_rd_en) |-> (b_addr_r != col_r[AW-1:0]),
                "line ram read and write hit the same entry")
  `PNGUF_ASSERT(a_eoi_has_eor, clk, rst_n,
                (out_valid && out_end_of_image) |-> out_end_of_row,
                "end of image without end of row")
  `PNGUF_ASSERT(a_bad_is_clean, clk, rst_n,
                (out_valid && out_bad_filter) |->
                  (out_pixel_byte == 8'd0 && !out_end_of_row && !out_end_of_image),
                "error result carries data or row flags")
  `PNGUF_ASSERT(a_stall_cause, clk, rst_n,
                !in_ready |-> (b_valid_r && b_ctl_r.emit && out_valid && !out_ready),
                "input stalled with no blocked result")
  `PNGUF_ASSERT_ALWAYS(a_reset_clears, clk,
                       !rst_n |=> (!out_valid && expect_type_r && !drop_r),
                       "reset did not clear control state")

endmodule

>>> bench/png_scanline_unfilter_tb.sv
`timescale 1ns / 100ps

module png_scanline_unfilter_tb;
  import pnguf_pkg::*;

  localparam int unsigned LINE_MAX     = 4096;
  localparam int unsigned PIXEL_MAX    = 8;
  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned CALM_TAIL    = 250;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  // one reconstructed byte or error marker as seen on the output channel
  typedef struct packed {
    logic [7:0] pixel;
    logic       bad;
    logic       eor;
    logic       eoi;
  } pixel_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BYTES_PER_PIXEL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_stream_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_pixel_byte;
  logic                  out_bad_filter;
  logic                  out_end_of_row;
  logic                  out_end_of_image;

  png_scanline_unfilter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_byte   (out_pixel_byte),
    .out_bad_filter   (out_bad_filter),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the unfilter: registers, line memory, histories and row tracking
  // ---------------------------------------------------------------------------
  logic [3:0]  bpp_reg = 4'd4;
  logic [12:0] rb_reg  = 13'd1024;
  logic [15:0] rc_reg  = 16'd1;

  logic [7:0]  line_mem [LINE_MAX];
  logic [7:0]  left_hist [PIXEL_MAX];
  logic [7:0]  upleft_hist [PIXEL_MAX];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [2:0]  cur_filter = FILT_NONE;
  bit          want_type = 1'b1;
  bit          dropping = 1'b0;

  pixel_result_t expected_pixels [$];
  logic [7:0]    filtered_bytes [$];
  int unsigned   bytes_in_flight = 0;   // queued or on the input port, not yet transferred
  int unsigned   queued_total = 0;
  int unsigned   mismatch_count = 0;

  // handshake bookkeeping, sampled at the rising edge, used at the falling edge
  logic byte_taken = 1'b0;
  logic cfg_taken = 1'b0;

  // idle control
  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;

  initial begin
    for (int k = 0; k < PIXEL_MAX; k++) begin
      left_hist[k] = '0;
      upleft_hist[k] = '0;
    end
  end

  function automatic int unsigned eff_pixel_bytes(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > PIXEL_MAX) return PIXEL_MAX;
    return v;
  endfunction

  function automatic int unsigned eff_row_bytes(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  function automatic int unsigned eff_row_count(input logic [15:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int absdiff(input int x, input int y);
    return (x > y) ? x - y : y - x;
  endfunction

  // paeth: whichever of a, b, c lies closest to a + b - c, ties go a, then b
  function automatic logic [7:0] paeth_nearest(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    int da;
    int db;
    int dc;
    da = absdiff(b, c);
    db = absdiff(a, c);
    dc = absdiff(int'(a) + int'(b), 2 * int'(c));
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_BYTES_PER_PIXEL: bpp_reg = v[3:0];
      CFG_ROW_BYTES:       rb_reg = v[12:0];
      CFG_ROW_COUNT:       rc_reg = v[15:0];
      default: ;
    endcase
  endfunction

  // advance the shadow by one stream byte and queue whatever result it causes
  function automatic void reconstruct_byte(input logic [7:0] x);
    int unsigned   bpp;
    int unsigned   rb;
    int unsigned   rc;
    int unsigned   col;
    int unsigned   slot;
    bit            has_left;
    bit            eor;
    bit            eoi;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic [7:0]    pred;
    logic [7:0]    recon;
    pixel_result_t res;
    bpp = eff_pixel_bytes(bpp_reg);
    rb = eff_row_bytes(rb_reg);
    rc = eff_row_count(rc_reg);
    col = col_pos;
    recon = '0;
    eor = 1'b0;
    eoi = 1'b0;

    if (want_type) begin
      want_type = 1'b0;
      col_pos = 0;
      if (dropping) return;
      if (x > FILT_PAETH) begin
        // unknown filter type: one error marker, then the image is skipped
        dropping = 1'b1;
        res = '{pixel: 8'h00, bad: 1'b1, eor: 1'b0, eoi: 1'b0};
        expected_pixels.push_back(res);
        return;
      end
      cur_filter = x[2:0];
      return;
    end

    if (!dropping) begin
      slot = col % bpp;
      has_left = (col >= bpp);
      a = has_left ? left_hist[slot] : 8'h00;
      c = has_left ? upleft_hist[slot] : 8'h00;
      b = (row_pos != 0) ? line_mem[col] : 8'h00;
      case (cur_filter)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_nearest(a, b, c);
        default:    pred = 8'h00;
      endcase
      recon = x + pred;
      upleft_hist[slot] = b;
      left_hist[slot] = recon;
      line_mem[col] = recon;
    end

    col++;
    if (col >= rb) begin
      col = 0;
      want_type = 1'b1;
      eor = 1'b1;
      row_pos++;
      if (row_pos >= rc) begin
        row_pos = 0;
        eoi = 1'b1;
      end
    end
    col_pos = col;

    if (dropping) begin
      if (eoi) dropping = 1'b0;
      return;
    end
    res = '{pixel: recon, bad: 1'b0, eor: eor, eoi: eoi};
    expected_pixels.push_back(res);
  endfunction

  // stream bytes still needed to bring the block back to an image start
  function automatic int unsigned bytes_to_image_end();
    int unsigned rb;
    int unsigned rc;
    int unsigned rows;
    int unsigned tail;
    rb = eff_row_bytes(rb_reg);
    rc = eff_row_count(rc_reg);
    if (want_type) begin
      if (row_pos == 0) return 0;
      rows = (row_pos >= rc) ? 1 : rc - row_pos;
      return rows * (rb + 1);
    end
    tail = (col_pos >= rb) ? 1 : rb - col_pos;
    rows = (row_pos + 1 >= rc) ? 0 : rc - row_pos - 1;
    return tail + rows * (rb + 1);
  endfunction

  // ---------------------------------------------------------------------------
  // rising edge: note transfers, update the shadow, compare results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_result_t want;
    byte_taken <= rst_n && in_valid && in_ready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) set_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        reconstruct_byte(in_stream_byte);
        bytes_in_flight--;
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result with nothing pending: pixel %02h bad %0b eor %0b eoi %0b",
                     $realtime, out_pixel_byte, out_bad_filter, out_end_of_row,
                     out_end_of_image);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_byte !== want.pixel || out_bad_filter !== want.bad ||
              out_end_of_row !== want.eor || out_end_of_image !== want.eoi) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch: got pixel %02h bad %0b eor %0b eoi %0b, want pixel %02h bad %0b eor %0b eoi %0b",
                       $realtime, out_pixel_byte, out_bad_filter, out_end_of_row,
                       out_end_of_image, want.pixel, want.bad, want.eor, want.eoi);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stream driver: next byte once the current one has transferred
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || byte_taken) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
        // idle burst: drop in_valid and load the gap counter at random
        tx_gap <= $urandom_range(17);
        in_valid <= 1'b0;
      end else if (filtered_bytes.size() != 0) begin
        in_stream_byte <= filtered_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      rx_gap <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (rx_pct != 0 && $urandom_range(99) < rx_pct) begin
      rx_gap <= $urandom_range(17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[png_scanline_unfilter] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] v);
    filtered_bytes.push_back(v);
    bytes_in_flight++;
    queued_total++;
  endtask

  task automatic push_row(input logic [2:0] kind, input logic [7:0] d0, input logic [7:0] d1);
    push_byte(8'(kind));
    push_byte(d0);
    push_byte(d1);
  endtask

  // corner values make paeth ties and mod-256 wraps far more likely
  function automatic logic [7:0] data_byte(input bit edgy);
    if (!edgy) return 8'($urandom);
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  // rows of type byte plus data at the current row length; bad_row < 0 means none
  task automatic emit_image(input int rows, input int bad_row, input bit edgy);
    int r;
    int unsigned rb;
    rb = eff_row_bytes(rb_reg);
    for (r = 0; r < rows; r++) begin
      if (r == bad_row) push_byte(8'($urandom_range(255, FILT_PAETH + 1)));
      else push_byte(8'($urandom_range(FILT_PAETH)));
      repeat (rb) push_byte(data_byte(edgy));
    end
  endtask

  // wait for every byte to transfer and every result to arrive, then let
  // the pipeline empty out
  task automatic settle();
    while (bytes_in_flight != 0 || expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write while idle; unless mid_image, finish the open image first.
  // growing the row length after the first row of an image is never done, since
  // the next row would read line memory that was never written
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v,
                             input bit mid_image);
    bit grows;
    int unsigned fill;
    settle();
    grows = (idx == CFG_ROW_BYTES) && (eff_row_bytes(v[12:0]) > eff_row_bytes(rb_reg));
    if (!mid_image || (grows && row_pos != 0)) begin
      fill = bytes_to_image_end();
      repeat (fill) push_byte(8'($urandom));
      settle();
    end
    cfg_index = idx;
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 30;
    endcase
  endfunction

  function automatic logic [15:0] pick_bpp();
    if ($urandom_range(7) == 0) return {12'($urandom), 4'($urandom_range(15))};
    return 16'($urandom_range(PIXEL_MAX, 1));
  endfunction

  function automatic logic [15:0] pick_rb();
    case ($urandom_range(19))
      0: return {3'($urandom), 13'd0};
      1: return 16'($urandom_range(300, 25));
      2: return {3'($urandom), 13'($urandom_range(24, 1))};
      default: return 16'($urandom_range(24, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_rc();
    if ($urandom_range(9) == 0) return 16'd0;
    return 16'($urandom_range(6, 1));
  endfunction

  initial begin
    int unsigned random_bytes;
    int unsigned start;
    int unsigned rc;
    int unsigned rb;
    int          n;
    bit          mid;
    bit          edgy;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    tx_pct = 15;
    rx_pct = 15;

    // reset values: 4 bytes per pixel, 1024-byte rows, one row per image
    emit_image(1, -1, 1'b0);

    // zero pixel distance with junk upper bits acts as 1; every filter once
    program_reg(CFG_BYTES_PER_PIXEL, 16'hFFF0, 1'b0);
    program_reg(CFG_ROW_BYTES, 16'd2, 1'b0);
    program_reg(CFG_ROW_COUNT, 16'd5, 1'b0);
    push_row(FILT_NONE, 8'hFF, 8'h00);
    push_row(FILT_SUB, 8'h00, 8'hFF);
    push_row(FILT_UP, 8'hFF, 8'hFF);
    push_row(FILT_AVG, 8'h80, 8'h7F);
    push_row(FILT_PAETH, 8'h01, 8'hFE);

    // zero row count acts as one row; smallest and largest bad types, then recovery
    program_reg(CFG_ROW_COUNT, 16'd0, 1'b0);
    push_byte(8'd5);
    push_byte(8'hAA);
    push_byte(8'h55);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'h02);
    push_row(FILT_SUB, 8'h10, 8'h20);

    // widest pixels and longest rows; the sink holds off meanwhile so the
    // block fills up and stalls its input
    program_reg(CFG_BYTES_PER_PIXEL, 16'd8, 1'b0);
    program_reg(CFG_ROW_BYTES, 16'd4096, 1'b0);
    program_reg(CFG_ROW_COUNT, 16'd2, 1'b0);
    settle();
    tx_pct = 0;
    hold_req = 1'b1;
    emit_image(2, -1, 1'b1);

    // out-of-range sizes clamp to the maximum
    program_reg(CFG_BYTES_PER_PIXEL, 16'd15, 1'b0);
    program_reg(CFG_ROW_BYTES, 16'h1FFF, 1'b0);
    program_reg(CFG_ROW_COUNT, 16'd1, 1'b0);
    tx_pct = 10;
    emit_image(1, -1, 1'b0);

    // changes inside an image: shorter rows end the current one at once,
    // a smaller row count ends the image at the next row end
    program_reg(CFG_BYTES_PER_PIXEL, 16'd3, 1'b0);
    program_reg(CFG_ROW_BYTES, 16'd20, 1'b0);
    program_reg(CFG_ROW_COUNT, 16'hFFFF, 1'b0);
    emit_image(4, -1, 1'b0);
    push_byte(8'(FILT_AVG));
    repeat (15) push_byte(data_byte(1'b0));
    program_reg(CFG_ROW_BYTES, 16'd5, 1'b1);
    push_byte(data_byte(1'b0));
    emit_image(2, -1, 1'b1);
    program_reg(CFG_ROW_COUNT, 16'd3, 1'b1);
    emit_image(1, -1, 1'b0);

    // random images, mostly well formed, some cut short or plain noise
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes + CALM_TAIL > RANDOM_BYTES) begin
        tx_pct = 0;
        rx_pct = 0;
      end else begin
        tx_pct = pick_pct();
        rx_pct = pick_pct();
      end
      mid = ($urandom_range(4) == 0);
      if ($urandom_range(1)) program_reg(CFG_BYTES_PER_PIXEL, pick_bpp(), mid);
      if ($urandom_range(1)) program_reg(CFG_ROW_BYTES, pick_rb(), mid);
      if ($urandom_range(1)) program_reg(CFG_ROW_COUNT, pick_rc(), mid);
      rc = eff_row_count(rc_reg);
      rb = eff_row_bytes(rb_reg);
      edgy = ($urandom_range(3) == 0);
      start = queued_total;
      case ($urandom_range(9))
        7: begin
          // image cut off inside a row
          emit_image($urandom_range(rc - 1), -1, edgy);
          push_byte(8'($urandom_range(FILT_PAETH)));
          repeat ($urandom_range(rb - 1)) push_byte(data_byte(edgy));
        end
        8: begin
          repeat ($urandom_range(12, 1)) push_byte(8'($urandom));
        end
        default: begin
          n = $urandom_range(3, 1);
          repeat (n) begin
            if ($urandom_range(5) == 0) emit_image(rc, $urandom_range(rc - 1), edgy);
            else emit_image(rc, -1, edgy);
          end
        end
      endcase
      random_bytes += queued_total - start;
    end

    settle();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("[png_scanline_unfilter] OK");
    end else begin
      $display("[png_scanline_unfilter] ERROR");
    end
    $finish;
  end

endmodule
